/* rtl/vtlv_pkg.sv */
// ----------------------------------------------------------------------------
// vtlv_pkg
// Types and constants shared by the varint TLV extension parser.
// ----------------------------------------------------------------------------
package vtlv_pkg;

  localparam int unsigned TagW   = 63;
  localparam int unsigned AccW   = 64;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [TagW-1:0] CerthashRst    = 63'd10;
  localparam logic [TagW-1:0] MuxerRst       = 63'd18;
  localparam logic [TagW-1:0] ReservedMaxRst = 63'd1024;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_CERTHASH     = 2'd0,
    CFG_MUXER        = 2'd1,
    CFG_RESERVED_MAX = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_LENGTH  = 2'd1,
    PH_PAYLOAD = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    KIND_NONE     = 2'd0,
    KIND_CERTHASH = 2'd1,
    KIND_MUXER    = 2'd2,
    KIND_IGNORED  = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_TOO_LONG  = 3'd1,
    ST_NONMIN    = 3'd2,
    ST_TRUNCATED = 3'd3,
    ST_RESERVED  = 3'd4
  } status_e;

  typedef struct packed {
    logic [TagW-1:0] certhash_tag;
    logic [TagW-1:0] muxer_tag;
    logic [TagW-1:0] reserved_max;
  } vtlv_cfg_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    kind_e      field_kind;
    logic       field_end;
    logic       message_done;
    status_e    status;
  } vtlv_res_t;

endpackage

/* rtl/varint_tlv_extension_parser.sv */
// ----------------------------------------------------------------------------
// varint_tlv_extension_parser
// Streaming parser for TLV extension messages built from LEB128 varints.
// ----------------------------------------------------------------------------
// Takes one message byte per word (tlast on the final byte) and returns one
// word per input byte. Records are a header varint, a length varint and that
// many payload bytes; payload bytes of known or experimental records come out
// tagged with their kind, field_end marks the byte that completes a record,
// and the first error is held and reported in status on the tlast word.
// Throughput is one byte per clock while the sink keeps tready high: the whole
// per-byte decode (varint merge, three tag compares, 64-bit payload countdown)
// sits between the input register and the result register. Tag registers
// may only be written while no message is in flight.
module varint_tlv_extension_parser #(
  parameter int unsigned MAX_VARINT_BYTES = 9
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration writes
  input  logic                          cfg_we_i,
  input  logic [vtlv_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [vtlv_pkg::TagW-1:0]     cfg_wdata_i,
  // byte stream in
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [7:0]                    s_axis_tdata_i,   // [7:0] data_byte
  input  logic                          s_axis_tlast_i,   // last_byte
  // result stream out
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [15:0]                   m_axis_tdata_o,   // [7:0] out_byte, [10:8] status
  output logic [3:0]                    m_axis_tuser_o,   // [0] byte_valid, [2:1] field_kind,
                                                          // [3] field_end
  output logic                          m_axis_tlast_o    // message_done
);
  import vtlv_pkg::*;

  vtlv_cfg_t  cfg_q, cfg_d;
  logic       in_vld_q, in_vld_d;
  logic [7:0] in_byte_q;
  logic       in_last_q;
  logic       out_vld_q, out_vld_d;
  vtlv_res_t  out_q, res;
  logic       out_free, step, s_fire;

  assign out_free        = !out_vld_q || m_axis_tready_i;
  assign step            = in_vld_q && out_free;
  assign s_axis_tready_o = !in_vld_q || out_free;
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_CERTHASH:     cfg_d.certhash_tag = cfg_wdata_i;
        CFG_MUXER:        cfg_d.muxer_tag    = cfg_wdata_i;
        CFG_RESERVED_MAX: cfg_d.reserved_max = cfg_wdata_i;
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    in_vld_d = in_vld_q;
    if (s_fire)    in_vld_d = 1'b1;
    else if (step) in_vld_d = 1'b0;
    out_vld_d = out_vld_q;
    if (step)                 out_vld_d = 1'b1;
    else if (m_axis_tready_i) out_vld_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.certhash_tag <= CerthashRst;
      cfg_q.muxer_tag    <= MuxerRst;
      cfg_q.reserved_max <= ReservedMaxRst;
      in_vld_q           <= 1'b0;
      out_vld_q          <= 1'b0;
    end else begin
      cfg_q     <= cfg_d;
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      in_byte_q <= s_axis_tdata_i;
      in_last_q <= s_axis_tlast_i;
    end
    if (step) out_q <= res;
  end

  vtlv_parser #(
    .MAX_VARINT_BYTES(MAX_VARINT_BYTES)
  ) u_parser (
    .clk_i,
    .rst_ni,
    .step_i   (step),
    .in_byte_i(in_byte_q),
    .in_last_i(in_last_q),
    .cfg_i    (cfg_q),
    .res_o    (res)
  );

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {5'd0, out_q.status, out_q.out_byte};
  assign m_axis_tuser_o  = {out_q.field_end, out_q.field_kind, out_q.byte_valid};
  assign m_axis_tlast_o  = out_q.message_done;

  a_status_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && out_q.status != ST_OK |-> m_axis_tlast_o)
    else $error("error status outside the message end word");

  a_valid_has_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && out_q.byte_valid |-> out_q.field_kind != KIND_NONE)
    else $error("payload byte without a field kind");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> in_vld_q && out_vld_q)
    else $error("input stalled with a free stage");

endmodule

/* rtl/vtlv_parser.sv */
// ----------------------------------------------------------------------------
// vtlv_parser
// Record parser state and per-byte decode: varint accumulation, header
// classification, payload countdown and sticky error tracking.
// ----------------------------------------------------------------------------
module vtlv_parser #(
  parameter int unsigned MAX_VARINT_BYTES = 9
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,     // consume in_byte_i this cycle
  input  logic [7:0]         in_byte_i,
  input  logic               in_last_i,
  input  vtlv_pkg::vtlv_cfg_t cfg_i,
  output vtlv_pkg::vtlv_res_t res_o
);
  import vtlv_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_VARINT_BYTES);
  localparam logic [CntW-1:0] CntLast = CntW'(MAX_VARINT_BYTES - 1);

  phase_e             phase_q, phase_s, phase_d;
  logic [AccW-1:0]    acc_q, acc_s, acc_d;
  logic [CntW-1:0]    cnt_q, cnt_s, cnt_d;
  kind_e              kind_q, kind_s, kind_d;
  logic [AccW-1:0]    left_q, left_s, left_d;
  status_e            err_q, err_s, err_d, err_fin;

  logic [6:0]         shamt;
  logic [AccW-1:0]    acc_new;
  logic               more, too_long, nonmin, vdone, len_zero, left_one;
  kind_e              hdr_kind;

  // varint byte decode
  assign shamt    = 7'(cnt_q) * 7'd7;
  assign acc_new  = acc_q | ({57'd0, in_byte_i[6:0]} << shamt);
  assign more     = in_byte_i[7];
  assign too_long = more && (cnt_q == CntLast);
  assign nonmin   = !more && (cnt_q != '0) && (in_byte_i == 8'd0);
  assign vdone    = !more && !nonmin;
  assign len_zero = (acc_new == '0);
  assign left_one = (left_q == AccW'(1));

  always_comb begin
    priority if (acc_new == {1'b0, cfg_i.certhash_tag}) hdr_kind = KIND_CERTHASH;
    else if (acc_new == {1'b0, cfg_i.muxer_tag})        hdr_kind = KIND_MUXER;
    else if (acc_new <= {1'b0, cfg_i.reserved_max})     hdr_kind = KIND_NONE;
    else                                                hdr_kind = KIND_IGNORED;
  end

  // next state for one byte, before the end-of-message clear
  always_comb begin
    phase_s = phase_q;
    acc_s   = acc_q;
    cnt_s   = cnt_q;
    kind_s  = kind_q;
    left_s  = left_q;
    err_s   = err_q;
    if (err_q == ST_OK) begin
      if (phase_q == PH_PAYLOAD) begin
        left_s = left_q - AccW'(1);
        if (left_one) begin
          if (kind_q == KIND_NONE) err_s = ST_RESERVED;
          phase_s = PH_HEADER;
        end
      end else if (more) begin
        if (too_long) begin
          err_s = ST_TOO_LONG;
        end else begin
          acc_s = acc_new;
          cnt_s = cnt_q + CntW'(1);
        end
      end else if (nonmin) begin
        err_s = ST_NONMIN;
      end else begin
        acc_s = '0;
        cnt_s = '0;
        if (phase_q == PH_HEADER) begin
          kind_s  = hdr_kind;
          phase_s = PH_LENGTH;
        end else begin
          left_s = acc_new;
          if (len_zero) begin
            if (kind_q == KIND_NONE) err_s = ST_RESERVED;
            phase_s = PH_HEADER;
          end else begin
            phase_s = PH_PAYLOAD;
          end
        end
      end
    end
  end

  // message end: flag truncation, then return to the idle record state
  always_comb begin
    err_fin = err_s;
    if (err_s == ST_OK && !(phase_s == PH_HEADER && cnt_s == '0)) err_fin = ST_TRUNCATED;
    if (in_last_i) begin
      phase_d = PH_HEADER;
      acc_d   = '0;
      cnt_d   = '0;
      kind_d  = KIND_NONE;
      left_d  = '0;
      err_d   = ST_OK;
    end else begin
      phase_d = phase_s;
      acc_d   = acc_s;
      cnt_d   = cnt_s;
      kind_d  = kind_s;
      left_d  = left_s;
      err_d   = err_s;
    end
  end

  // result word
  always_comb begin
    res_o              = '0;
    res_o.field_kind   = KIND_NONE;
    res_o.status       = ST_OK;
    res_o.message_done = in_last_i;
    if (err_q == ST_OK) begin
      if (phase_q == PH_PAYLOAD) begin
        if (kind_q != KIND_NONE) begin
          res_o.out_byte   = in_byte_i;
          res_o.byte_valid = 1'b1;
          res_o.field_kind = kind_q;
          res_o.field_end  = left_one;
        end
      end else if (phase_q == PH_LENGTH) begin
        if (vdone && len_zero && kind_q != KIND_NONE) begin
          res_o.field_kind = kind_q;
          res_o.field_end  = 1'b1;
        end
      end
    end
    if (in_last_i) res_o.status = err_fin;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER;
      acc_q   <= '0;
      cnt_q   <= '0;
      kind_q  <= KIND_NONE;
      left_q  <= '0;
      err_q   <= ST_OK;
    end else if (step_i) begin
      phase_q <= phase_d;
      acc_q   <= acc_d;
      cnt_q   <= cnt_d;
      kind_q  <= kind_d;
      left_q  <= left_d;
      err_q   <= err_d;
    end
  end

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && in_last_i |=> phase_q == PH_HEADER && err_q == ST_OK && cnt_q == '0)
    else $error("parser state not cleared after message end");

  a_err_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    err_q != ST_OK && !(step_i && in_last_i) |=> $stable(err_q))
    else $error("sticky error changed inside a message");

  a_payload_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_PAYLOAD && err_q == ST_OK |-> left_q != '0)
    else $error("payload phase with nothing left");

endmodule

/* dv/tb_varint_tlv_extension_parser.sv */
// ----------------------------------------------------------------------------
// tb_varint_tlv_extension_parser
// Self-checking bench for the varint TLV extension parser. A short directed
// message set, then random messages (mostly well-formed records, plus noise,
// corrupt varints and cut messages) under several tag settings. The bytes go
// in through a randomly gapped source and the results come out through a
// randomly stalled sink. Every result word is checked field by field against
// a cycle-free software parser kept inside the bench.
// ----------------------------------------------------------------------------
module tb_varint_tlv_extension_parser;
  timeunit 1ns;
  timeprecision 1ps;

  import vtlv_pkg::*;

  localparam int unsigned MaxVarint = 9;
  localparam int unsigned Limit = 1000000;
  localparam int unsigned PhaseBytes = 90;
  localparam logic [TagW-1:0] TagMax = {TagW{1'b1}};
  // index past the register list, the write has to be dropped
  localparam logic [CfgIdxW-1:0] CfgIdxSpare = 2'd3;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } msg_byte_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [TagW-1:0]     cfg_wdata;
  logic                s_tvalid;
  logic                s_tready;
  logic [7:0]          s_tdata;
  logic                s_tlast;
  logic                m_tvalid;
  logic                m_tready;
  logic [15:0]         m_tdata;
  logic [3:0]          m_tuser;
  logic                m_tlast;

  varint_tlv_extension_parser #(
    .MAX_VARINT_BYTES(MaxVarint)
  ) u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tlast_o  (m_tlast)
  );

  // bytes waiting for the source, parse results waiting for the sink
  msg_byte_t   byte_q[$];
  vtlv_res_t   res_due_q[$];
  logic [7:0]  msg[$];

  // parser shadow state and tag registers
  phase_e      ps_phase;
  logic [63:0] ps_acc;
  logic [3:0]  ps_cnt;
  kind_e       ps_kind;
  logic [63:0] ps_left;
  status_e     ps_err;
  logic [TagW-1:0] cert_tag;
  logic [TagW-1:0] mux_tag;
  logic [TagW-1:0] resv_max;

  int unsigned cycles;
  int unsigned bytes_queued;
  int unsigned bytes_taken;
  int unsigned n_err;
  int unsigned n_msgs;
  int unsigned n_payload;
  int unsigned n_records;
  int unsigned n_settings;
  int unsigned status_seen[5];
  bit          in_fire;
  bit          idle_on;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // shadow parser
  // ---------------------------------------------------------------------------
  function automatic bit varint_take(logic [7:0] b);
    int unsigned sh;
    sh = 7 * ps_cnt;
    if (sh < 64) ps_acc |= 64'(b[6:0]) << sh;
    ps_cnt++;
    if (b[7]) begin
      if (ps_cnt >= MaxVarint) ps_err = ST_TOO_LONG;
      return 1'b0;
    end
    if (ps_cnt > 1 && b == 8'h00) begin
      ps_err = ST_NONMIN;
      return 1'b0;
    end
    ps_cnt = '0;
    return 1'b1;
  endfunction

  function automatic void parser_clear();
    ps_phase = PH_HEADER;
    ps_acc   = '0;
    ps_cnt   = '0;
    ps_kind  = KIND_NONE;
    ps_left  = '0;
    ps_err   = ST_OK;
  endfunction

  function automatic vtlv_res_t parse_byte(logic [7:0] b, logic last);
    vtlv_res_t   r;
    logic [63:0] h;
    r = '0;
    if (ps_err == ST_OK) begin
      case (ps_phase)
        PH_HEADER: begin
          if (varint_take(b)) begin
            h = ps_acc;
            // cert tag wins over muxer tag, both win over the reserved range
            if (h == {1'b0, cert_tag}) ps_kind = KIND_CERTHASH;
            else if (h == {1'b0, mux_tag}) ps_kind = KIND_MUXER;
            else if (h <= {1'b0, resv_max}) ps_kind = KIND_NONE;
            else ps_kind = KIND_IGNORED;
            ps_acc   = '0;
            ps_phase = PH_LENGTH;
          end
        end
        PH_LENGTH: begin
          if (varint_take(b)) begin
            ps_left = ps_acc;
            ps_acc  = '0;
            if (ps_left == 0) begin
              if (ps_kind == KIND_NONE) begin
                ps_err = ST_RESERVED;
              end else begin
                r.field_end  = 1'b1;
                r.field_kind = ps_kind;
              end
              ps_phase = PH_HEADER;
            end else begin
              ps_phase = PH_PAYLOAD;
            end
          end
        end
        default: begin
          ps_left--;
          if (ps_kind != KIND_NONE) begin
            r.out_byte   = b;
            r.byte_valid = 1'b1;
            r.field_kind = ps_kind;
          end
          // reserved records are swallowed, the error lands on their end
          if (ps_left == 0) begin
            if (ps_kind == KIND_NONE) ps_err = ST_RESERVED;
            else r.field_end = 1'b1;
            ps_phase = PH_HEADER;
          end
        end
      endcase
    end
    if (last) begin
      if (ps_err == ST_OK && !(ps_phase == PH_HEADER && ps_cnt == 0)) ps_err = ST_TRUNCATED;
      r.status       = ps_err;
      r.message_done = 1'b1;
      status_seen[int'(ps_err)]++;
      n_msgs++;
      parser_clear();
    end
    if (r.byte_valid) n_payload++;
    if (r.field_end) n_records++;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // message building
  // ---------------------------------------------------------------------------
  function automatic logic [TagW-1:0] rand_wide();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[TagW-1:0] >> $urandom_range(0, TagW - 1);
  endfunction

  function automatic logic [TagW-1:0] pick_header();
    logic [TagW-1:0] span;
    logic [TagW-1:0] k;
    case ($urandom_range(0, 6))
      0, 1: return cert_tag;
      2, 3: return mux_tag;
      4, 5: begin
        if (resv_max == TagMax) return cert_tag;
        span = TagMax - resv_max;
        k = $urandom_range(0, 1) ? TagW'($urandom_range(0, 50)) : rand_wide();
        return resv_max + 1 + (k % span);
      end
      default: begin
        k = $urandom_range(0, 1) ? TagW'($urandom_range(0, 40)) : rand_wide();
        return (resv_max == TagMax) ? k : k % (resv_max + 1);
      end
    endcase
  endfunction

  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 15);
    if (r < 4) return 0;
    if (r < 13) return $urandom_range(1, 6);
    if (r < 15) return $urandom_range(7, 20);
    return $urandom_range(128, 180);
  endfunction

  // pad adds a redundant 0x00 group, which makes the varint non-minimal
  task automatic put_varint(logic [TagW-1:0] v, bit pad);
    logic [TagW-1:0] x;
    x = v;
    while (x >= 128) begin
      msg.push_back({1'b1, x[6:0]});
      x = x >> 7;
    end
    if (pad) begin
      msg.push_back({1'b1, x[6:0]});
      msg.push_back(8'h00);
    end else begin
      msg.push_back({1'b0, x[6:0]});
    end
  endtask

  task automatic flush_msg();
    foreach (msg[i]) byte_q.push_back('{data: msg[i], last: (i == msg.size() - 1)});
    bytes_queued += msg.size();
    msg.delete();
  endtask

  task automatic gen_message();
    int mode;
    int nrec;
    int bad;
    int len;
    int plen;
    int cut;
    logic [TagW-1:0] hdr;
    logic [TagW-1:0] lenv;
    msg.delete();
    mode = $urandom_range(0, 19);
    if (mode < 2) begin
      repeat ($urandom_range(1, 10)) msg.push_back(8'($urandom));
    end else begin
      nrec = $urandom_range(1, 4);
      bad  = $urandom_range(0, nrec - 1);
      for (int i = 0; i < nrec; i++) begin
        hdr  = pick_header();
        len  = pick_len();
        lenv = TagW'(len);
        plen = len;
        if (mode == 7 && i == nrec - 1) begin
          // length far beyond the message end
          lenv = rand_wide() | TagW'(1);
          plen = $urandom_range(0, 3);
        end
        if (mode == 4 && i == bad) begin
          repeat (MaxVarint) msg.push_back(8'h80 | 8'($urandom_range(0, 127)));
        end
        put_varint(hdr, mode == 2 && i == bad);
        put_varint(lenv, mode == 3 && i == bad);
        repeat (plen) msg.push_back(8'($urandom));
      end
      if ((mode == 5 || mode == 6) && msg.size() > 1) begin
        cut = $urandom_range(1, msg.size() - 1);
        while (msg.size() > cut) void'(msg.pop_back());
      end
    end
    flush_msg();
  endtask

  // ---------------------------------------------------------------------------
  // register writes and drain
  // ---------------------------------------------------------------------------
  task automatic write_cfg(logic [CfgIdxW-1:0] idx, logic [TagW-1:0] v);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= v;
    if (idx == CFG_CERTHASH) cert_tag = v;
    else if (idx == CFG_MUXER) mux_tag = v;
    else if (idx == CFG_RESERVED_MAX) resv_max = v;
  endtask

  task automatic end_cfg();
    @(negedge clk_i);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  task automatic wait_drain();
    do @(negedge clk_i);
    while (bytes_taken != bytes_queued || res_due_q.size() != 0);
    // input and result registers are empty, wait on before touching the tags
    repeat (4) @(negedge clk_i);
  endtask

  task automatic report(string what, logic [7:0] got, logic [7:0] want);
    if (n_err < 30) begin
      $display("%0t: %s mismatch, got 0x%0h want 0x%0h", $realtime, what, got, want);
    end
    n_err++;
  endtask

  // ---------------------------------------------------------------------------
  // source: one byte word per handshake, random gaps
  // ---------------------------------------------------------------------------
  int unsigned src_gap;
  int unsigned snk_gap;

  always @(negedge clk_i) begin
    msg_byte_t nb;
    if (rst_ni && (!s_tvalid || in_fire)) begin
      if (src_gap == 0 && idle_on && $urandom_range(0, 7) == 0) src_gap = $urandom_range(1, 18);
      if (src_gap > 0) begin
        src_gap--;
        s_tvalid <= 1'b0;
      end else if (byte_q.size() > 0) begin
        nb = byte_q.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= nb.data;
        s_tlast  <= nb.last;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // sink: random stall bursts
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (snk_gap == 0 && idle_on && $urandom_range(0, 7) == 0) snk_gap = $urandom_range(1, 18);
      if (snk_gap > 0) begin
        snk_gap--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: predict on accepted bytes, check accepted result words
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    vtlv_res_t got;
    vtlv_res_t want;
    if (!rst_ni) begin
      in_fire = 1'b0;
    end else if (cycles > Limit) begin
      $display("Verification failed");
      $finish;
    end else begin
      cycles++;
      in_fire = s_tvalid && s_tready;
      if (in_fire) begin
        res_due_q.push_back(parse_byte(s_tdata, s_tlast));
        bytes_taken++;
      end
      if (m_tvalid && m_tready) begin
        got.out_byte     = m_tdata[7:0];
        got.status       = status_e'(m_tdata[10:8]);
        got.byte_valid   = m_tuser[0];
        got.field_kind   = kind_e'(m_tuser[2:1]);
        got.field_end    = m_tuser[3];
        got.message_done = m_tlast;
        if (res_due_q.size() == 0) begin
          report("unexpected word", m_tdata[7:0], 8'h00);
        end else begin
          want = res_due_q.pop_front();
          if (got.out_byte !== want.out_byte) report("out_byte", got.out_byte, want.out_byte);
          if (got.byte_valid !== want.byte_valid) begin
            report("byte_valid", 8'(got.byte_valid), 8'(want.byte_valid));
          end
          if (got.field_kind !== want.field_kind) begin
            report("field_kind", 8'(got.field_kind), 8'(want.field_kind));
          end
          if (got.field_end !== want.field_end) begin
            report("field_end", 8'(got.field_end), 8'(want.field_end));
          end
          if (got.message_done !== want.message_done) begin
            report("message_done", 8'(got.message_done), 8'(want.message_done));
          end
          if (got.status !== want.status) report("status", 8'(got.status), 8'(want.status));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned start;
    rst_ni    <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_idx   <= CFG_CERTHASH;
    cfg_wdata <= '0;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tlast   <= 1'b0;
    m_tready  <= 1'b0;
    idle_on   = 1'b1;
    cert_tag  = CerthashRst;
    mux_tag   = MuxerRst;
    resv_max  = ReservedMaxRst;
    n_settings = 1;
    parser_clear();
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed, on reset tag values
    msg = '{8'h0A, 8'h02, 8'h00, 8'hFF};                 // cert hash, payload extremes
    flush_msg();
    msg = '{8'h12, 8'h00, 8'hD0, 8'h0F, 8'h01, 8'h5A};   // empty muxer, experimental 2000
    flush_msg();
    msg = '{8'h05, 8'h01, 8'h33};                        // reserved header
    flush_msg();
    msg = '{8'h05, 8'h80, 8'h00};                        // non-minimal inside reserved record
    flush_msg();
    repeat (MaxVarint) msg.push_back(8'hFF);             // too-long header
    flush_msg();
    msg = '{8'h0A};                                      // ends right after the header
    flush_msg();
    msg = '{8'h8A};                                      // ends inside a varint
    flush_msg();

    for (int p = 1; p <= 8; p++) begin
      wait_drain();
      case (p)
        1: begin
          write_cfg(CFG_CERTHASH, '0);
          write_cfg(CFG_MUXER, TagMax);
          write_cfg(CFG_RESERVED_MAX, '0);
        end
        2: begin
          write_cfg(CFG_CERTHASH, TagMax);
          write_cfg(CFG_MUXER, '0);
          write_cfg(CFG_RESERVED_MAX, TagMax);
        end
        3: begin
          write_cfg(CfgIdxSpare, rand_wide());
          write_cfg(CFG_CERTHASH, TagW'($urandom_range(0, 300)));
          write_cfg(CFG_MUXER, TagW'($urandom_range(0, 300)));
          write_cfg(CFG_RESERVED_MAX, TagW'($urandom_range(0, 2000)));
        end
        8: begin
          write_cfg(CFG_CERTHASH, CerthashRst);
          write_cfg(CFG_MUXER, MuxerRst);
          write_cfg(CFG_RESERVED_MAX, ReservedMaxRst);
        end
        default: begin
          write_cfg(CFG_CERTHASH, rand_wide());
          write_cfg(CFG_MUXER, rand_wide());
          write_cfg(CFG_RESERVED_MAX, rand_wide());
        end
      endcase
      end_cfg();
      idle_on = (p != 5 && p != 8);
      start = bytes_queued;
      while (bytes_queued - start < PhaseBytes) gen_message();
    end

    wait_drain();
    repeat (8) @(posedge clk_i);
    if (res_due_q.size() != 0) report("missing words", 8'(res_due_q.size()), 8'h00);
    $display("Run: %0d messages, %0d bytes, %0d payload words, %0d closed records, %0d tag sets",
             n_msgs, bytes_taken, n_payload, n_records, n_settings);
    $display("Message status: ok %0d, too long %0d, non-minimal %0d, truncated %0d, reserved %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4]);
    if (n_err == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
